### hw/rtl/sfc_pkg.sv
`default_nettype none

package sfc_pkg;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 3;
    localparam int MASK_W  = 6;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_MASK = 2'd1,
        KIND_TEST = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic issue;
        logic kill;
        logic start;
    } dot_ctl_t;

    typedef struct packed {
        logic busy;
        logic valid;
        logic outside;
        logic contained;
    } verdict_t;

endpackage

`default_nettype wire

### hw/rtl/sphere_frustum_cull_test.sv
// Sphere versus clip-plane culling test.
// The request channel (in_valid/in_ready) carries three kinds of requests:
// a plane load, which writes one plane's normal and offset; a mask write,
// which replaces the active plane mask; and a sphere test.  The result
// channel (out_valid/out_ready) carries one result per sphere test only.
// Loads and mask writes leave the block idle, so it stays ready for the next
// request.  A sphere test walks plane indices one per cycle through the
// shared three-multiplier dot-product unit, which has a two-stage pipeline;
// a cull stops the walk early.  in_ready is low during a test, so no new
// request is taken until the test's result has been loaded into the output
// register.
// The cfg_write_en/cfg_write_data port sets the option that clears mask bits
// of planes that fully contain a tested sphere; the user must write it only
// when idle, and nothing in the block enforces this.  Reset clears the active
// mask, the option and all control state; plane storage holds no defined
// value until loaded.  A finished result waits in the output register while
// the receiver stalls, and further loads and mask writes are accepted
// meanwhile; a following test ends its walk and then waits for it to free up.
`default_nettype none

module sphere_frustum_cull_test #(
    parameter int PLANE_COUNT  = 6,
    parameter int COORD_WIDTH  = 32,
    parameter int NORMAL_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [sfc_pkg::KIND_W-1:0]     kind,
    input  wire logic [sfc_pkg::INDEX_W-1:0]    plane_index,
    input  wire logic signed [NORMAL_WIDTH-1:0] normal_x,
    input  wire logic signed [NORMAL_WIDTH-1:0] normal_y,
    input  wire logic signed [NORMAL_WIDTH-1:0] normal_z,
    input  wire logic signed [COORD_WIDTH-1:0]  plane_offset,
    input  wire logic [sfc_pkg::MASK_W-1:0]     new_mask,
    input  wire logic signed [COORD_WIDTH-1:0]  center_x,
    input  wire logic signed [COORD_WIDTH-1:0]  center_y,
    input  wire logic signed [COORD_WIDTH-1:0]  center_z,
    input  wire logic [COORD_WIDTH-2:0]         sphere_radius,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                visible,
    output logic [sfc_pkg::MASK_W-1:0]          mask_after,
    input  wire logic                           cfg_write_en,
    input  wire logic                           cfg_write_data
);
    import sfc_pkg::*;

    localparam int IW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    dot_ctl_t                       ctl;
    verdict_t                       verdict;
    logic                           wr_en;
    logic [IW-1:0]                  wr_idx;
    logic [IW-1:0]                  rd_idx;
    logic signed [NORMAL_WIDTH-1:0] rd_nx;
    logic signed [NORMAL_WIDTH-1:0] rd_ny;
    logic signed [NORMAL_WIDTH-1:0] rd_nz;
    logic signed [COORD_WIDTH-1:0]  rd_offset;

    sfc_ctrl #(
        .PLANE_COUNT(PLANE_COUNT)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .plane_index    (plane_index),
        .new_mask       (new_mask),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .visible        (visible),
        .mask_after     (mask_after),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .verdict        (verdict),
        .ctl            (ctl),
        .wr_en          (wr_en),
        .wr_idx         (wr_idx),
        .rd_idx         (rd_idx)
    );

    sfc_plane_store #(
        .PLANE_COUNT (PLANE_COUNT),
        .COORD_WIDTH (COORD_WIDTH),
        .NORMAL_WIDTH(NORMAL_WIDTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_nx     (normal_x),
        .wr_ny     (normal_y),
        .wr_nz     (normal_z),
        .wr_offset (plane_offset),
        .rd_idx    (rd_idx),
        .rd_nx     (rd_nx),
        .rd_ny     (rd_ny),
        .rd_nz     (rd_nz),
        .rd_offset (rd_offset)
    );

    sfc_dot_unit #(
        .COORD_WIDTH (COORD_WIDTH),
        .NORMAL_WIDTH(NORMAL_WIDTH)
    ) u_dot (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .sphere_radius (sphere_radius),
        .nx            (rd_nx),
        .ny            (rd_ny),
        .nz            (rd_nz),
        .offset        (rd_offset),
        .verdict       (verdict)
    );

    // The dot-product pipeline never holds work while requests are taken.
    assert property (@(posedge clk) disable iff (!rst_n) verdict.busy |-> !in_ready)
        else $error("dot pipeline busy while ready");

    assert property (@(posedge clk) disable iff (!rst_n) ctl.issue |-> !in_ready)
        else $error("plane issued while ready");

    // A cull flushes every plane still in flight.
    assert property (@(posedge clk) disable iff (!rst_n) ctl.kill |=> !verdict.busy)
        else $error("pipeline not flushed after cull");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == KIND_TEST)) |=> !in_ready)
        else $error("ready right after sphere test accepted");

endmodule

`default_nettype wire

### hw/rtl/sfc_plane_store.sv
`default_nettype none

module sfc_plane_store #(
    parameter int PLANE_COUNT  = 6,
    parameter int COORD_WIDTH  = 32,
    parameter int NORMAL_WIDTH = 16,
    localparam int IW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [IW-1:0]                  wr_idx,
    input  wire logic signed [NORMAL_WIDTH-1:0] wr_nx,
    input  wire logic signed [NORMAL_WIDTH-1:0] wr_ny,
    input  wire logic signed [NORMAL_WIDTH-1:0] wr_nz,
    input  wire logic signed [COORD_WIDTH-1:0]  wr_offset,
    input  wire logic [IW-1:0]                  rd_idx,
    output logic signed [NORMAL_WIDTH-1:0]      rd_nx,
    output logic signed [NORMAL_WIDTH-1:0]      rd_ny,
    output logic signed [NORMAL_WIDTH-1:0]      rd_nz,
    output logic signed [COORD_WIDTH-1:0]       rd_offset
);

    logic signed [NORMAL_WIDTH-1:0] nx_reg [PLANE_COUNT];
    logic signed [NORMAL_WIDTH-1:0] ny_reg [PLANE_COUNT];
    logic signed [NORMAL_WIDTH-1:0] nz_reg [PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0]  off_reg [PLANE_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            nx_reg[wr_idx]  <= wr_nx;
            ny_reg[wr_idx]  <= wr_ny;
            nz_reg[wr_idx]  <= wr_nz;
            off_reg[wr_idx] <= wr_offset;
        end
    end

    assign rd_nx     = nx_reg[rd_idx];
    assign rd_ny     = ny_reg[rd_idx];
    assign rd_nz     = nz_reg[rd_idx];
    assign rd_offset = off_reg[rd_idx];

endmodule

`default_nettype wire

### hw/rtl/sfc_dot_unit.sv
`default_nettype none

module sfc_dot_unit #(
    parameter int COORD_WIDTH  = 32,
    parameter int NORMAL_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire sfc_pkg::dot_ctl_t              ctl,
    input  wire logic signed [COORD_WIDTH-1:0]  center_x,
    input  wire logic signed [COORD_WIDTH-1:0]  center_y,
    input  wire logic signed [COORD_WIDTH-1:0]  center_z,
    input  wire logic [COORD_WIDTH-2:0]         sphere_radius,
    input  wire logic signed [NORMAL_WIDTH-1:0] nx,
    input  wire logic signed [NORMAL_WIDTH-1:0] ny,
    input  wire logic signed [NORMAL_WIDTH-1:0] nz,
    input  wire logic signed [COORD_WIDTH-1:0]  offset,
    output sfc_pkg::verdict_t                   verdict
);
    import sfc_pkg::*;

    localparam int PW = NORMAL_WIDTH + COORD_WIDTH;
    localparam int DW = NORMAL_WIDTH + COORD_WIDTH + 2;
    localparam int RW = COORD_WIDTH + NORMAL_WIDTH - 2;

    logic signed [COORD_WIDTH-1:0] cx_reg;
    logic signed [COORD_WIDTH-1:0] cy_reg;
    logic signed [COORD_WIDTH-1:0] cz_reg;
    logic [COORD_WIDTH-2:0]        r_reg;
    logic signed [PW-1:0]          px_reg;
    logic signed [PW-1:0]          py_reg;
    logic signed [PW-1:0]          pz_reg;
    logic signed [COORD_WIDTH-1:0] off_reg;
    logic signed [DW-1:0]          d_reg;
    logic signed [DW-1:0]          d_next;
    logic signed [DW-1:0]          off_scaled;
    logic signed [DW-1:0]          r_scaled;
    logic                          v1_reg;
    logic                          v1_next;
    logic                          v2_reg;
    logic                          v2_next;

    always_comb
    begin
        off_scaled = DW'(off_reg) <<< (NORMAL_WIDTH - 1);
        d_next     = DW'(px_reg) + DW'(py_reg) + DW'(pz_reg) - off_scaled;
        r_scaled   = $signed({{(DW - RW){1'b0}}, r_reg, {(NORMAL_WIDTH - 1){1'b0}}});
        v1_next    = ctl.issue;
        v2_next    = v1_reg && !ctl.kill;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            cz_reg <= center_z;
            r_reg  <= sphere_radius;
        end
        if (ctl.issue)
        begin
            px_reg  <= nx * cx_reg;
            py_reg  <= ny * cy_reg;
            pz_reg  <= nz * cz_reg;
            off_reg <= offset;
        end
        if (v1_reg)
        begin
            d_reg <= d_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_comb
    begin
        verdict.busy      = v1_reg || v2_reg;
        verdict.valid     = v2_reg;
        verdict.outside   = d_reg <= -r_scaled;
        verdict.contained = d_reg >= r_scaled;
    end

endmodule

`default_nettype wire

### hw/rtl/sfc_ctrl.sv
`default_nettype none

module sfc_ctrl #(
    parameter int PLANE_COUNT = 6,
    localparam int IW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sfc_pkg::KIND_W-1:0]    kind,
    input  wire logic [sfc_pkg::INDEX_W-1:0]   plane_index,
    input  wire logic [sfc_pkg::MASK_W-1:0]    new_mask,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               visible,
    output logic [sfc_pkg::MASK_W-1:0]         mask_after,
    input  wire logic                          cfg_write_en,
    input  wire logic                          cfg_write_data,
    input  wire sfc_pkg::verdict_t             verdict,
    output sfc_pkg::dot_ctl_t                  ctl,
    output logic                               wr_en,
    output logic [IW-1:0]                      wr_idx,
    output logic [IW-1:0]                      rd_idx
);
    import sfc_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(PLANE_COUNT - 1);

    state_t                     state_reg;
    state_t                     state_next;
    logic [PLANE_COUNT-1:0]     mask_reg;
    logic [PLANE_COUNT-1:0]     mask_next;
    logic                       opt_reg;
    logic [IW-1:0]              iss_idx_reg;
    logic [IW-1:0]              iss_idx_next;
    logic                       issuing_reg;
    logic                       issuing_next;
    logic [IW-1:0]              idx1_reg;
    logic [IW-1:0]              idx2_reg;
    logic                       vis_reg;
    logic                       vis_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       visible_reg;
    logic [MASK_W-1:0]          mask_after_reg;
    logic                       accept;
    logic                       is_load;
    logic                       is_mask;
    logic                       is_test;
    logic                       fin_load;
    logic [PLANE_COUNT+MASK_W-1:0] new_mask_wide;
    logic [MASK_W+PLANE_COUNT-1:0] mask_wide;
    logic [IW+INDEX_W-1:0]      index_wide;

    assign accept        = in_valid && in_ready;
    assign new_mask_wide = {{PLANE_COUNT{1'b0}}, new_mask};
    assign mask_wide     = {{MASK_W{1'b0}}, mask_reg};
    assign index_wide    = {{IW{1'b0}}, plane_index};

    always_comb
    begin
        is_load = 1'b0;
        is_mask = 1'b0;
        is_test = 1'b0;
        unique case (kind_t'(kind))
            KIND_LOAD: is_load = 1'b1;
            KIND_MASK: is_mask = 1'b1;
            KIND_TEST: is_test = 1'b1;
            default:   is_load = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_test)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if ((verdict.valid && verdict.outside) || (!issuing_reg && !verdict.busy))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = state_reg == ST_IDLE;
        ctl.kill  = (state_reg == ST_WALK) && verdict.valid && verdict.outside;
        ctl.issue = (state_reg == ST_WALK) && issuing_reg && mask_reg[iss_idx_reg] && !ctl.kill;
        ctl.start = accept && is_test;
        rd_idx    = iss_idx_reg;
        wr_en     = accept && is_load && (int'(plane_index) < PLANE_COUNT);
        wr_idx    = index_wide[IW-1:0];
        fin_load  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        mask_next      = mask_reg;
        issuing_next   = issuing_reg;
        iss_idx_next   = iss_idx_reg;
        vis_next       = vis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept && is_mask)
        begin
            mask_next = new_mask_wide[PLANE_COUNT-1:0];
        end
        if (ctl.start)
        begin
            issuing_next = 1'b1;
            iss_idx_next = '0;
            vis_next     = 1'b1;
        end
        if (state_reg == ST_WALK)
        begin
            if (issuing_reg)
            begin
                iss_idx_next = iss_idx_reg + 1'b1;
                if (iss_idx_reg == LAST_IDX)
                begin
                    issuing_next = 1'b0;
                end
            end
            if (ctl.kill)
            begin
                issuing_next = 1'b0;
                vis_next     = 1'b0;
            end
            else if (verdict.valid && verdict.contained && opt_reg)
            begin
                mask_next[idx2_reg] = 1'b0;
            end
        end
        if (fin_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            opt_reg       <= 1'b0;
            iss_idx_reg   <= '0;
            issuing_reg   <= 1'b0;
            idx1_reg      <= '0;
            idx2_reg      <= '0;
            vis_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            iss_idx_reg   <= iss_idx_next;
            issuing_reg   <= issuing_next;
            idx1_reg      <= iss_idx_reg;
            idx2_reg      <= idx1_reg;
            vis_reg       <= vis_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                opt_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            visible_reg    <= vis_reg;
            mask_after_reg <= mask_wide[MASK_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign visible    = visible_reg;
    assign mask_after = mask_after_reg;

endmodule

`default_nettype wire
